>>> hw/rtl/tiny_accumulator_isa_core_macros.svh
// Assertion macros for the tiny accumulator ISA core.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef TINY_ACCUMULATOR_ISA_CORE_MACROS_SVH
`define TINY_ACCUMULATOR_ISA_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define TAI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TAI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tai_pkg.sv
// Shared types, ISA codes and the microcode ROM of the tiny accumulator ISA core.
// No dependencies.
package tai_pkg;

  typedef logic [15:0] word_t;

  typedef enum logic [1:0] {
    CAUSE_NONE  = 2'd0,
    CAUSE_HALT  = 2'd1,
    CAUSE_DIVZ  = 2'd2,
    CAUSE_BADOP = 2'd3
  } cause_t;

  typedef enum logic [3:0] {
    OPC_LDI   = 4'h1,
    OPC_ADD   = 4'h2,
    OPC_STORE = 4'h3,
    OPC_SUB   = 4'h4,
    OPC_MUL   = 4'h5,
    OPC_DIV   = 4'h6,
    OPC_JMP   = 4'h7,
    OPC_HALT  = 4'hF
  } opc_t;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  localparam int DIV_STEPS = 16;

  typedef enum logic [4:0] {
    UOP_NOP,
    UOP_CLEAR,
    UOP_ACCEPT,
    UOP_REDUCE,
    UOP_LOADW,
    UOP_FETCH,
    UOP_DECODE,
    UOP_LDI,
    UOP_ADD,
    UOP_SUB,
    UOP_MUL,
    UOP_STSET,
    UOP_STORE,
    UOP_JUMP,
    UOP_HALT,
    UOP_BADOP,
    UOP_DIVINIT,
    UOP_DIVSTEP,
    UOP_DIVDONE,
    UOP_DIVZ,
    UOP_RESP
  } uop_t;

  typedef enum logic [3:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_CLR,
    JC_ITEM,
    JC_ADDROK,
    JC_DISPATCH,
    JC_DIVZ,
    JC_COUNT,
    JC_OUTFREE
  } jc_t;

  typedef logic [4:0] upc_t;

  localparam upc_t UA_CLEAR   = 5'd0;
  localparam upc_t UA_IDLE    = 5'd1;
  localparam upc_t UA_LDRED   = 5'd2;
  localparam upc_t UA_LDWR    = 5'd3;
  localparam upc_t UA_FETCH   = 5'd4;
  localparam upc_t UA_DECODE  = 5'd5;
  localparam upc_t UA_LDI     = 5'd6;
  localparam upc_t UA_ADD     = 5'd7;
  localparam upc_t UA_SUB     = 5'd8;
  localparam upc_t UA_MUL     = 5'd9;
  localparam upc_t UA_STSET   = 5'd10;
  localparam upc_t UA_STRED   = 5'd11;
  localparam upc_t UA_STWR    = 5'd12;
  localparam upc_t UA_JUMP    = 5'd13;
  localparam upc_t UA_HALT    = 5'd14;
  localparam upc_t UA_BAD     = 5'd15;
  localparam upc_t UA_DIVCHK  = 5'd16;
  localparam upc_t UA_DIVSTEP = 5'd17;
  localparam upc_t UA_DIVDONE = 5'd18;
  localparam upc_t UA_DIVZ    = 5'd19;
  localparam upc_t UA_RESP    = 5'd20;

  typedef struct packed {
    uop_t op;
    jc_t  jc;
    upc_t target;
  } ucw_t;

  function automatic ucw_t ucode(upc_t addr);
    ucw_t cw;
    case (addr)
      UA_CLEAR:   cw = '{op: UOP_CLEAR,   jc: JC_CLR,      target: UA_IDLE};
      UA_IDLE:    cw = '{op: UOP_ACCEPT,  jc: JC_ITEM,     target: UA_IDLE};
      UA_LDRED:   cw = '{op: UOP_REDUCE,  jc: JC_ADDROK,   target: UA_LDWR};
      UA_LDWR:    cw = '{op: UOP_LOADW,   jc: JC_ALWAYS,   target: UA_RESP};
      UA_FETCH:   cw = '{op: UOP_FETCH,   jc: JC_NEXT,     target: UA_DECODE};
      UA_DECODE:  cw = '{op: UOP_DECODE,  jc: JC_DISPATCH, target: UA_BAD};
      UA_LDI:     cw = '{op: UOP_LDI,     jc: JC_ALWAYS,   target: UA_RESP};
      UA_ADD:     cw = '{op: UOP_ADD,     jc: JC_ALWAYS,   target: UA_RESP};
      UA_SUB:     cw = '{op: UOP_SUB,     jc: JC_ALWAYS,   target: UA_RESP};
      UA_MUL:     cw = '{op: UOP_MUL,     jc: JC_ALWAYS,   target: UA_RESP};
      UA_STSET:   cw = '{op: UOP_STSET,   jc: JC_NEXT,     target: UA_STRED};
      UA_STRED:   cw = '{op: UOP_REDUCE,  jc: JC_ADDROK,   target: UA_STWR};
      UA_STWR:    cw = '{op: UOP_STORE,   jc: JC_ALWAYS,   target: UA_RESP};
      UA_JUMP:    cw = '{op: UOP_JUMP,    jc: JC_ALWAYS,   target: UA_RESP};
      UA_HALT:    cw = '{op: UOP_HALT,    jc: JC_ALWAYS,   target: UA_RESP};
      UA_BAD:     cw = '{op: UOP_BADOP,   jc: JC_ALWAYS,   target: UA_RESP};
      UA_DIVCHK:  cw = '{op: UOP_DIVINIT, jc: JC_DIVZ,     target: UA_DIVZ};
      UA_DIVSTEP: cw = '{op: UOP_DIVSTEP, jc: JC_COUNT,    target: UA_DIVDONE};
      UA_DIVDONE: cw = '{op: UOP_DIVDONE, jc: JC_ALWAYS,   target: UA_RESP};
      UA_DIVZ:    cw = '{op: UOP_DIVZ,    jc: JC_ALWAYS,   target: UA_RESP};
      UA_RESP:    cw = '{op: UOP_RESP,    jc: JC_OUTFREE,  target: UA_IDLE};
      default:    cw = '{op: UOP_NOP,     jc: JC_ALWAYS,   target: UA_IDLE};
    endcase
    return cw;
  endfunction

  function automatic upc_t dispatch(logic [3:0] opc);
    upc_t entry;
    case (opc)
      OPC_LDI:   entry = UA_LDI;
      OPC_ADD:   entry = UA_ADD;
      OPC_STORE: entry = UA_STSET;
      OPC_SUB:   entry = UA_SUB;
      OPC_MUL:   entry = UA_MUL;
      OPC_DIV:   entry = UA_DIVCHK;
      OPC_JMP:   entry = UA_JUMP;
      OPC_HALT:  entry = UA_HALT;
      default:   entry = UA_BAD;
    endcase
    return entry;
  endfunction

endpackage

>>> hw/rtl/tai_in_if.sv
// Input channel of the tiny accumulator ISA core: valid/ready plus item payload.
// Depends on tai_pkg.
interface tai_in_if;
  logic          valid;
  logic          ready;
  logic          opcode;
  tai_pkg::word_t load_address;
  tai_pkg::word_t load_word;

  modport source (output valid, output opcode, output load_address, output load_word,
                  input ready);
  modport sink   (input valid, input opcode, input load_address, input load_word,
                  output ready);
endinterface

>>> hw/rtl/tai_out_if.sv
// Result channel of the tiny accumulator ISA core: valid/ready plus processor state.
// Depends on tai_pkg.
interface tai_out_if;
  logic             valid;
  logic             ready;
  tai_pkg::word_t   program_counter;
  tai_pkg::word_t   reg0;
  tai_pkg::word_t   reg1;
  tai_pkg::word_t   reg2;
  tai_pkg::word_t   reg3;
  logic             zero_flag;
  logic             is_halted;
  tai_pkg::cause_t  halt_cause;

  modport source (output valid, output program_counter, output reg0, output reg1,
                  output reg2, output reg3, output zero_flag, output is_halted,
                  output halt_cause, input ready);
  modport sink   (input valid, input program_counter, input reg0, input reg1,
                  input reg2, input reg3, input zero_flag, input is_halted,
                  input halt_cause, output ready);
endinterface

>>> hw/rtl/tiny_accumulator_isa_core.sv
// Top level of the tiny accumulator ISA core: microcoded sequencer, datapath, word memory.
// Depends on tai_pkg, tai_in_if, tai_out_if and tiny_accumulator_isa_core_macros.svh.
//
// Usage:
//   in_ch carries one item per valid/ready transfer. opcode 0 writes load_word into the
//   word memory and rewinds the processor; opcode 1 executes one instruction unless halted.
//   out_ch returns exactly one result per item: program counter, four registers, zero
//   flag, halt state and cause after that item.
//   A load or store address at or above MEM_WORDS is brought into range by repeated
//   subtraction of MEM_WORDS. A step while halted goes straight to its result.
//   The divide is a restoring divider that resolves one quotient bit per microcode
//   step. Instruction fetch uses the single read port of the word memory.
//   After reset the microcode clears the word memory, one word per cycle;
//   in_ch.ready stays low during that pass.
//   Results sit in an output register; a stalled receiver holds it, and the next item
//   is still taken and executed, waiting only at its own result step for the register
//   to free up.
module tiny_accumulator_isa_core #(
  parameter int unsigned MEM_WORDS = 65536
) (
  input  logic      clk,
  input  logic      rst_n,
  tai_in_if.sink    in_ch,
  tai_out_if.source out_ch
);

  `include "tiny_accumulator_isa_core_macros.svh"

  localparam int unsigned AW = $clog2(MEM_WORDS);
  localparam logic [16:0] MemLimit = 17'(MEM_WORDS);
  localparam logic [AW-1:0] ClrLast = AW'(MEM_WORDS - 1);
  localparam logic [3:0] DivLast = 4'(tai_pkg::DIV_STEPS - 1);

  tai_pkg::upc_t   upc_r, upc_nxt;
  tai_pkg::ucw_t   cw;

  logic [3:0][15:0] gp_r;
  tai_pkg::word_t  pc_r;
  logic            zero_r;
  logic            halted_r;
  tai_pkg::cause_t cause_r;
  logic [AW-1:0]   clr_cnt_r;
  logic            out_valid_r;

  tai_pkg::word_t  addr_r;
  tai_pkg::word_t  word_r;
  tai_pkg::word_t  insn_r;
  tai_pkg::word_t  div_q_r;
  tai_pkg::word_t  div_rem_r;
  logic [3:0]      div_cnt_r;
  tai_pkg::word_t  rd_data_r;

  tai_pkg::word_t  out_pc_r;
  logic [3:0][15:0] out_gp_r;
  logic            out_zero_r;
  logic            out_halted_r;
  tai_pkg::cause_t out_cause_r;

  tai_pkg::word_t  mem [MEM_WORDS];

  logic            in_accept;
  logic            out_free;
  logic            addr_ok;
  logic            mem_we;
  logic            mem_re;
  logic [AW-1:0]   mem_wa;
  tai_pkg::word_t  mem_wd;

  tai_pkg::word_t  op_d, op_s;
  tai_pkg::word_t  alu_sum, alu_diff;
  logic [31:0]     prod;
  logic [16:0]     pc_inc;
  tai_pkg::word_t  pc_seq;
  logic [16:0]     rem_sh;
  logic [16:0]     rem_sub;
  logic            div_ge;

  // microcode fetch and control decode
  always_comb begin
    cw          = tai_pkg::ucode(upc_r);
    in_ch.ready = (cw.op == tai_pkg::UOP_ACCEPT);
    mem_re      = (cw.op == tai_pkg::UOP_FETCH);
    mem_we      = 1'b0;
    mem_wa      = addr_r[AW-1:0];
    mem_wd      = op_d;
    case (cw.op)
      tai_pkg::UOP_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
        mem_wd = '0;
      end
      tai_pkg::UOP_LOADW: begin
        mem_we = 1'b1;
        mem_wd = word_r;
      end
      tai_pkg::UOP_STORE: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign in_accept = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign addr_ok   = ({1'b0, addr_r} < MemLimit);

  assign op_d     = gp_r[insn_r[9:8]];
  assign op_s     = gp_r[insn_r[1:0]];
  assign alu_sum  = op_d + op_s;
  assign alu_diff = op_d - op_s;
  assign prod     = 32'(op_d) * 32'(op_s);
  assign pc_inc   = {1'b0, pc_r} + 17'd1;
  assign pc_seq   = (pc_inc == MemLimit) ? '0 : pc_inc[15:0];
  assign rem_sh   = {div_rem_r, div_q_r[15]};
  assign div_ge   = (rem_sh >= {1'b0, op_s});
  assign rem_sub  = rem_sh - {1'b0, op_s};

  // next microcode address
  always_comb begin
    upc_nxt = upc_r + 5'd1;
    case (cw.jc)
      tai_pkg::JC_NEXT:     upc_nxt = upc_r + 5'd1;
      tai_pkg::JC_ALWAYS:   upc_nxt = cw.target;
      tai_pkg::JC_CLR:      upc_nxt = (clr_cnt_r == ClrLast) ? cw.target : upc_r;
      tai_pkg::JC_ITEM: begin
        if (!in_ch.valid) begin
          upc_nxt = upc_r;
        end else if (in_ch.opcode == tai_pkg::KIND_LOAD) begin
          upc_nxt = tai_pkg::UA_LDRED;
        end else if (halted_r) begin
          upc_nxt = tai_pkg::UA_RESP;
        end else begin
          upc_nxt = tai_pkg::UA_FETCH;
        end
      end
      tai_pkg::JC_ADDROK:   upc_nxt = addr_ok ? cw.target : upc_r;
      tai_pkg::JC_DISPATCH: upc_nxt = tai_pkg::dispatch(rd_data_r[15:12]);
      tai_pkg::JC_DIVZ:     upc_nxt = (op_s == '0) ? cw.target : upc_r + 5'd1;
      tai_pkg::JC_COUNT:    upc_nxt = (div_cnt_r == DivLast) ? cw.target : upc_r;
      tai_pkg::JC_OUTFREE:  upc_nxt = out_free ? cw.target : upc_r;
      default:              upc_nxt = tai_pkg::UA_IDLE;
    endcase
  end

  // sequencer and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= tai_pkg::UA_CLEAR;
      gp_r        <= '0;
      pc_r        <= '0;
      zero_r      <= 1'b0;
      halted_r    <= 1'b0;
      cause_r     <= tai_pkg::CAUSE_NONE;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r <= upc_nxt;
      if ((cw.op == tai_pkg::UOP_RESP) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (cw.op)
        tai_pkg::UOP_CLEAR: clr_cnt_r <= clr_cnt_r + AW'(1);
        tai_pkg::UOP_LOADW: begin
          pc_r     <= '0;
          halted_r <= 1'b0;
          cause_r  <= tai_pkg::CAUSE_NONE;
        end
        tai_pkg::UOP_LDI: begin
          gp_r[insn_r[9:8]] <= {8'h00, insn_r[7:0]};
          pc_r              <= pc_seq;
        end
        tai_pkg::UOP_ADD: begin
          gp_r[insn_r[9:8]] <= alu_sum;
          zero_r            <= (alu_sum == '0);
          pc_r              <= pc_seq;
        end
        tai_pkg::UOP_SUB: begin
          gp_r[insn_r[9:8]] <= alu_diff;
          zero_r            <= (alu_diff == '0);
          pc_r              <= pc_seq;
        end
        tai_pkg::UOP_MUL: begin
          gp_r[insn_r[9:8]] <= prod[15:0];
          zero_r            <= (prod[15:0] == '0);
          pc_r              <= pc_seq;
        end
        tai_pkg::UOP_STORE: pc_r <= pc_seq;
        tai_pkg::UOP_JUMP:  pc_r <= {4'h0, insn_r[11:0]};
        tai_pkg::UOP_HALT: begin
          halted_r <= 1'b1;
          cause_r  <= tai_pkg::CAUSE_HALT;
        end
        tai_pkg::UOP_BADOP: begin
          halted_r <= 1'b1;
          cause_r  <= tai_pkg::CAUSE_BADOP;
        end
        tai_pkg::UOP_DIVZ: begin
          halted_r <= 1'b1;
          cause_r  <= tai_pkg::CAUSE_DIVZ;
        end
        tai_pkg::UOP_DIVDONE: begin
          gp_r[insn_r[9:8]] <= div_q_r;
          zero_r            <= (div_q_r == '0);
          pc_r              <= pc_seq;
        end
        default: begin
        end
      endcase
    end
  end

  // item, instruction, divider and result payload
  always_ff @(posedge clk) begin
    case (cw.op)
      tai_pkg::UOP_ACCEPT: begin
        if (in_accept) begin
          addr_r <= in_ch.load_address;
          word_r <= in_ch.load_word;
        end
      end
      tai_pkg::UOP_REDUCE: begin
        if (!addr_ok) begin
          addr_r <= 16'({1'b0, addr_r} - MemLimit);
        end
      end
      tai_pkg::UOP_DECODE: insn_r <= rd_data_r;
      tai_pkg::UOP_STSET:  addr_r <= op_s;
      tai_pkg::UOP_DIVINIT: begin
        div_q_r   <= op_d;
        div_rem_r <= '0;
        div_cnt_r <= '0;
      end
      tai_pkg::UOP_DIVSTEP: begin
        div_rem_r <= div_ge ? rem_sub[15:0] : rem_sh[15:0];
        div_q_r   <= {div_q_r[14:0], div_ge};
        div_cnt_r <= div_cnt_r + 4'd1;
      end
      tai_pkg::UOP_RESP: begin
        if (out_free) begin
          out_pc_r     <= pc_r;
          out_gp_r     <= gp_r;
          out_zero_r   <= zero_r;
          out_halted_r <= halted_r;
          out_cause_r  <= cause_r;
        end
      end
      default: begin
      end
    endcase
  end

  // word memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[pc_r[AW-1:0]];
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.program_counter = out_pc_r;
  assign out_ch.reg0            = out_gp_r[0];
  assign out_ch.reg1            = out_gp_r[1];
  assign out_ch.reg2            = out_gp_r[2];
  assign out_ch.reg3            = out_gp_r[3];
  assign out_ch.zero_flag       = out_zero_r;
  assign out_ch.is_halted       = out_halted_r;
  assign out_ch.halt_cause      = out_cause_r;

  `TAI_ASSERT_NOW(a_cause_matches_halt, 1'b1,
    (halted_r == (cause_r != tai_pkg::CAUSE_NONE)), "halt state and cause disagree")
  `TAI_ASSERT_NOW(a_pc_in_range, 1'b1,
    ({1'b0, pc_r} < MemLimit), "program counter outside word memory")
  `TAI_ASSERT_NEXT(a_halted_step_skips,
    (in_accept && (in_ch.opcode == tai_pkg::KIND_STEP) && halted_r),
    (upc_r == tai_pkg::UA_RESP), "step while halted did not go straight to result")
  `TAI_ASSERT_NOW(a_divdone_after_steps, (upc_r == tai_pkg::UA_DIVDONE),
    ($past(upc_r) == tai_pkg::UA_DIVSTEP), "divide finished without iterating")

endmodule

>>> bench/tb_top.sv
// Self-checking bench for tiny_accumulator_isa_core: directed rows, then random programs.
// Keeps its own model of registers, flags and word memory and checks every result transfer.
// Depends on tai_pkg, tai_in_if, tai_out_if and the core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tai_pkg::*;

  typedef struct packed {
    word_t  pc;
    word_t  r0;
    word_t  r1;
    word_t  r2;
    word_t  r3;
    logic   zf;
    logic   halted;
    cause_t cause;
  } snapshot_t;

  typedef struct packed {
    logic      kind;
    word_t     addr;
    word_t     word;
    logic      typed;
    snapshot_t want;
  } stim_row_t;

  localparam logic [3:0] OPC_UNUSED = 4'h0;
  localparam int ITEM_TARGET = 500;
  localparam int LONG_HOLD_AT = 120;
  localparam int LONG_HOLD_CYCLES = 300;

  localparam snapshot_t CLEAN_REWIND = '0;
  localparam snapshot_t BADOP_AT_ZERO = '{pc: 16'h0000, r0: 16'h0000, r1: 16'h0000,
                                          r2: 16'h0000, r3: 16'h0000, zf: 1'b0,
                                          halted: 1'b1, cause: CAUSE_BADOP};

  localparam int DIRECTED_ROWS = 25;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{KIND_STEP, 16'h0000, 16'h0000, 1'b1, BADOP_AT_ZERO},
    '{KIND_STEP, 16'h0000, 16'h0000, 1'b1, BADOP_AT_ZERO},
    '{KIND_LOAD, 16'hFFFF, 16'hFFFF, 1'b1, CLEAN_REWIND},
    '{KIND_LOAD, 16'h0000, 16'h10FF, 1'b1, CLEAN_REWIND},
    '{KIND_LOAD, 16'h0001, 16'h5000, 1'b1, CLEAN_REWIND},
    '{KIND_LOAD, 16'h0002, 16'h2100, 1'b1, CLEAN_REWIND},
    '{KIND_LOAD, 16'h0003, 16'h2101, 1'b1, CLEAN_REWIND},
    '{KIND_LOAD, 16'h0004, 16'h4303, 1'b1, CLEAN_REWIND},
    '{KIND_LOAD, 16'h0005, 16'h4300, 1'b1, CLEAN_REWIND},
    '{KIND_LOAD, 16'h0006, 16'h6003, 1'b1, CLEAN_REWIND},
    '{KIND_LOAD, 16'h0007, 16'h3201, 1'b1, CLEAN_REWIND},
    '{KIND_LOAD, 16'h0008, 16'h6102, 1'b1, CLEAN_REWIND},
    '{KIND_STEP, 16'h0000, 16'h0000, 1'b0, CLEAN_REWIND},
    '{KIND_STEP, 16'h0000, 16'h0000, 1'b0, CLEAN_REWIND},
    '{KIND_STEP, 16'h0000, 16'h0000, 1'b0, CLEAN_REWIND},
    '{KIND_STEP, 16'h0000, 16'h0000, 1'b0, CLEAN_REWIND},
    '{KIND_STEP, 16'h0000, 16'h0000, 1'b0, CLEAN_REWIND},
    '{KIND_STEP, 16'h0000, 16'h0000, 1'b0, CLEAN_REWIND},
    '{KIND_STEP, 16'h0000, 16'h0000, 1'b0, CLEAN_REWIND},
    '{KIND_STEP, 16'h0000, 16'h0000, 1'b0, CLEAN_REWIND},
    '{KIND_STEP, 16'h0000, 16'h0000, 1'b0, CLEAN_REWIND},
    '{KIND_LOAD, 16'h0000, 16'h7FFF, 1'b0, CLEAN_REWIND},
    '{KIND_LOAD, 16'h0FFF, 16'hF000, 1'b0, CLEAN_REWIND},
    '{KIND_STEP, 16'h0000, 16'h0000, 1'b0, CLEAN_REWIND},
    '{KIND_STEP, 16'h0000, 16'h0000, 1'b0, CLEAN_REWIND}
  };

  logic clk;
  logic rst_n;

  tai_in_if  in_ch ();
  tai_out_if out_ch ();

  tiny_accumulator_isa_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  word_t  cpu_mem [65536] = '{default: '0};
  word_t  cpu_gpr [4] = '{default: '0};
  word_t  cpu_pc = '0;
  logic   cpu_zero = 1'b0;
  logic   cpu_halted = 1'b0;
  cause_t cpu_cause = CAUSE_NONE;

  snapshot_t awaited_states [$];
  int failures = 0;
  int results_seen = 0;
  int items_sent = 0;
  bit offering = 1'b0;

  function automatic snapshot_t advance_core(logic kind, word_t addr, word_t word);
    word_t insn;
    logic [1:0] dst;
    logic [1:0] src;
    logic bump;
    if (kind == KIND_LOAD) begin
      cpu_mem[addr] = word;
      cpu_pc = '0;
      cpu_halted = 1'b0;
      cpu_cause = CAUSE_NONE;
    end else if (!cpu_halted) begin
      insn = cpu_mem[cpu_pc];
      dst = insn[9:8];
      src = insn[1:0];
      bump = 1'b1;
      case (insn[15:12])
        OPC_LDI: cpu_gpr[dst] = {8'h00, insn[7:0]};
        OPC_ADD: begin
          cpu_gpr[dst] = cpu_gpr[dst] + cpu_gpr[src];
          cpu_zero = (cpu_gpr[dst] == '0);
        end
        OPC_STORE: cpu_mem[cpu_gpr[src]] = cpu_gpr[dst];
        OPC_SUB: begin
          cpu_gpr[dst] = cpu_gpr[dst] - cpu_gpr[src];
          cpu_zero = (cpu_gpr[dst] == '0);
        end
        OPC_MUL: begin
          cpu_gpr[dst] = cpu_gpr[dst] * cpu_gpr[src];
          cpu_zero = (cpu_gpr[dst] == '0);
        end
        OPC_DIV: begin
          if (cpu_gpr[src] == '0) begin
            cpu_halted = 1'b1;
            cpu_cause = CAUSE_DIVZ;
            bump = 1'b0;
          end else begin
            cpu_gpr[dst] = cpu_gpr[dst] / cpu_gpr[src];
            cpu_zero = (cpu_gpr[dst] == '0);
          end
        end
        OPC_JMP: begin
          cpu_pc = {4'h0, insn[11:0]};
          bump = 1'b0;
        end
        OPC_HALT: begin
          cpu_halted = 1'b1;
          cpu_cause = CAUSE_HALT;
          bump = 1'b0;
        end
        default: begin
          cpu_halted = 1'b1;
          cpu_cause = CAUSE_BADOP;
          bump = 1'b0;
        end
      endcase
      if (bump) cpu_pc = cpu_pc + 16'd1;
    end
    return '{cpu_pc, cpu_gpr[0], cpu_gpr[1], cpu_gpr[2], cpu_gpr[3], cpu_zero, cpu_halted,
             cpu_cause};
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic word_t random_insn(int span);
    word_t raw;
    logic [3:0] opc;
    int pick;
    raw = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 12) opc = OPC_LDI;
    else if (pick < 26) opc = OPC_ADD;
    else if (pick < 36) opc = OPC_STORE;
    else if (pick < 48) opc = OPC_SUB;
    else if (pick < 60) opc = OPC_MUL;
    else if (pick < 72) opc = OPC_DIV;
    else if (pick < 82) opc = OPC_JMP;
    else if (pick < 88) opc = OPC_HALT;
    else begin
      opc = 4'($urandom_range(8, 15));
      if (opc == OPC_HALT) opc = OPC_UNUSED;
    end
    if (opc == OPC_JMP && $urandom_range(0, 3) != 0) raw[11:0] = 12'($urandom_range(0, span - 1));
    return {opc, raw[11:0]};
  endfunction

  task automatic issue_item(input logic kind, input word_t addr, input word_t word,
                            input logic typed, input snapshot_t want, input bit steady);
    snapshot_t predicted;
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.opcode <= kind;
    in_ch.load_address <= addr;
    in_ch.load_word <= word;
    offering = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predicted = advance_core(kind, addr, word);
    awaited_states.push_back(typed ? want : predicted);
    items_sent++;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    while (awaited_states.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(input string label, input logic [15:0] expected,
                               input logic [15:0] actual);
    if (expected !== actual) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, label, expected, actual);
      failures++;
    end
  endtask

  task automatic check_result();
    snapshot_t want;
    results_seen++;
    if (awaited_states.size() == 0) begin
      $display("%0t ns: result transfer with nothing awaited, expected none, actual pc %h",
               $time, out_ch.program_counter);
      failures++;
    end else begin
      want = awaited_states.pop_front();
      compare_field("program_counter", want.pc, out_ch.program_counter);
      compare_field("reg0", want.r0, out_ch.reg0);
      compare_field("reg1", want.r1, out_ch.reg1);
      compare_field("reg2", want.r2, out_ch.reg2);
      compare_field("reg3", want.r3, out_ch.reg3);
      compare_field("zero_flag", 16'(want.zf), 16'(out_ch.zero_flag));
      compare_field("is_halted", 16'(want.halted), 16'(out_ch.is_halted));
      compare_field("halt_cause", 16'(want.cause), 16'(out_ch.halt_cause));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int stall_left;
    int calm_left;
    int gap;
    bit long_hold_done;
    stall_left = 0;
    calm_left = 0;
    long_hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) check_result();
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        out_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 3) begin
        calm_left = $urandom_range(20, 80);
        out_ch.ready <= 1'b1;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          stall_left = gap - 1;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    bit steady;
    int span;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= KIND_LOAD;
    in_ch.load_address <= '0;
    in_ch.load_word <= '0;
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i])
      issue_item(DIRECTED[i].kind, DIRECTED[i].addr, DIRECTED[i].word, DIRECTED[i].typed,
                 DIRECTED[i].want, 1'b0);
    drain_results();

    while (items_sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 5) == 0) drain_results();
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3))
          issue_item(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 1'b0, CLEAN_REWIND, steady);
      span = $urandom_range(2, 12);
      for (int i = 0; i < span; i++)
        issue_item(KIND_LOAD, 16'(i), random_insn(span), 1'b0, CLEAN_REWIND, steady);
      repeat ($urandom_range(span, 3 * span + 4))
        issue_item(KIND_STEP, 16'($urandom()), 16'($urandom()), 1'b0, CLEAN_REWIND, steady);
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
